[rtl/tagged_bit_packer_top_assert.svh]
// assertion macros for the tagged bit packer engine
`ifndef TAGGED_BIT_PACKER_TOP_ASSERT_SVH
`define TAGGED_BIT_PACKER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define TBP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tagged bit packer assertion failed");

// next-cycle implication
`define TBP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tagged bit packer assertion failed");

`endif

[rtl/tbp_pkg.sv]
// shared types and constants for the tagged bit packer
package tbp_pkg;

   localparam int unsigned STORE_BYTES = 4096;
   localparam int unsigned TAG_BITS    = 5;
   localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
   localparam int unsigned ALLOC_W     = ADDR_W + 1;
   localparam int unsigned CURSOR_W    = ADDR_W + 4;
   localparam int unsigned MAX_BITS    = 32;
   localparam int unsigned NBITS_W     = 6;
   localparam int unsigned WIN_BYTES   = MAX_BITS / 8 + 1;
   localparam int unsigned WIN_W       = WIN_BYTES * 8;
   localparam int unsigned BYTE_IDX_W  = $clog2(WIN_BYTES);

   localparam int unsigned REQ_TDATA_W = 48;
   localparam int unsigned REQ_TUSER_W = 3;
   localparam int unsigned RSP_TDATA_W = 64;
   localparam int unsigned RSP_TUSER_W = 4;

   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_USE_TAGS = 0;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_REWIND = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_NONE = 3'd0,
      ST_ZERO = 3'd1,
      ST_PAST = 3'd2,
      ST_TAG  = 3'd3,
      ST_FULL = 3'd4
   } status_type;

   typedef struct packed {
      op_type               op;
      logic                 typed;
      logic [TAG_BITS-1:0]  tag;
      logic [NBITS_W-1:0]   nbits;
      logic [MAX_BITS-1:0]  write_value;
   } req_word_type;

   typedef struct packed {
      logic                 ok;
      logic [MAX_BITS-1:0]  read_value;
      status_type           status;
      logic [CURSOR_W-1:0]  cursor_bits;
      logic [ALLOC_W-1:0]   used_bytes;
   } rsp_word_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

endpackage

[rtl/tagged_bit_packer_top.sv]
// clear sweeps the store one byte a cycle
// one word at a time: the next word is taken only after the result has passed to the output register
// after reset the store is swept to zero with req_tready low
// csr writes are taken during the sweep; use_tags resets to 0
module tagged_bit_packer_top
   import tbp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // tag, nbits, write_value
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // op, typed
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // read_value, cursor_bits, used_bytes
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // ok, status
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic         use_tags_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   req_word_type req_word;
   rsp_word_type eng_word;
   logic         eng_valid;
   logic         eng_ready;
   mem_req_type  mem_req;
   logic [7:0]   mem_rdata;
   logic         csr_hit;

   always_comb begin
      req_word.op          = op_type'(req_tuser[1:0]);
      req_word.typed       = req_tuser[2];
      req_word.tag         = req_tdata[TAG_BITS-1:0];
      req_word.nbits       = req_tdata[TAG_BITS +: NBITS_W];
      req_word.write_value = req_tdata[TAG_BITS+NBITS_W +: MAX_BITS];
   end

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == 1'(CSR_USE_TAGS));
   assign csr_prdata = csr_hit ? {31'b0, use_tags_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_tags_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         use_tags_ff <= csr_pwdata[0];
      end
   end

   // output register parts the engine from the result channel
   assign eng_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_valid && eng_ready) begin
         rsp_valid_ff <= 1'b1;
         rsp_word_ff  <= eng_word;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_word_ff.used_bytes, rsp_word_ff.cursor_bits,
                                     rsp_word_ff.read_value});
   assign rsp_tuser  = {rsp_word_ff.status, rsp_word_ff.ok};

   tbp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .use_tags  (use_tags_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_word  (req_word),
      .rsp_valid (eng_valid),
      .rsp_ready (eng_ready),
      .rsp_word  (eng_word),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   tbp_store u_store (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (mem_rdata)
   );

endmodule

[rtl/tbp_store.sv]
// byte-wide store, one write port and one registered read port
module tbp_store
   import tbp_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rd_data_ff
);

   logic [7:0] mem_ff [STORE_BYTES];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem_ff[mem_req.raddr];
   end

endmodule

[rtl/tbp_engine.sv]
// sequencer: bit cursor, allocation and byte read-modify-write over the store
`include "tagged_bit_packer_top_assert.svh"

module tbp_engine
   import tbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         use_tags,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   output mem_req_type  mem_req,
   input  logic [7:0]   mem_rdata
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_STEP,
      S_RMW,
      S_FIN,
      S_RESP
   } state_type;

   state_type              state_ff;
   logic [ADDR_W-1:0]      clr_addr_ff;
   logic                   clr_reply_ff;
   req_word_type           item_ff;
   logic                   tag_phase_ff;
   logic [CURSOR_W-1:0]    cursor_ff;
   logic [ALLOC_W-1:0]     alloc_ff;
   logic [WIN_W-1:0]       wval_ff;
   logic [WIN_W-1:0]       wmask_ff;
   logic [WIN_W-1:0]       rwin_ff;
   logic [BYTE_IDX_W-1:0]  k_ff;
   status_type             status_ff;
   logic [MAX_BITS-1:0]    rval_ff;

   logic [NBITS_W-1:0]     nbits_sat;
   logic [NBITS_W-1:0]     step_bits;
   logic [MAX_BITS-1:0]    step_val;
   logic                   is_wr;
   logic [2:0]             off;
   logic [ADDR_W-1:0]      base;
   logic [BYTE_IDX_W-1:0]  grow;
   logic [ALLOC_W:0]       alloc_sum;
   logic                   full;
   logic [CURSOR_W-1:0]    alloc_bits;
   logic [CURSOR_W:0]      cur_end;
   logic                   past;
   logic [NBITS_W:0]       span;
   logic [BYTE_IDX_W-1:0]  last_k;
   logic [MAX_BITS-1:0]    mask32;
   logic [WIN_W-1:0]       win_val;
   logic [WIN_W-1:0]       win_mask;
   logic [WIN_W-1:0]       rd_shift;
   logic [MAX_BITS-1:0]    rd_bits;
   logic [ADDR_W-1:0]      cur_addr;

   always_comb begin
      nbits_sat  = (item_ff.nbits > NBITS_W'(MAX_BITS)) ? NBITS_W'(MAX_BITS) : item_ff.nbits;
      step_bits  = tag_phase_ff ? NBITS_W'(TAG_BITS) : nbits_sat;
      step_val   = tag_phase_ff ? MAX_BITS'(item_ff.tag) : item_ff.write_value;
      is_wr      = (item_ff.op == OP_WRITE);
      off        = cursor_ff[2:0];
      base       = cursor_ff[ADDR_W+2:3];
      // growth is floor(bits/8)+1 bytes
      grow       = BYTE_IDX_W'(step_bits[NBITS_W-1:3]) + BYTE_IDX_W'(1);
      alloc_sum  = {1'b0, alloc_ff} + (ALLOC_W+1)'(grow);
      full       = alloc_sum > (ALLOC_W+1)'(STORE_BYTES);
      alloc_bits = {alloc_ff, 3'b000};
      cur_end    = {1'b0, cursor_ff} + (CURSOR_W+1)'(step_bits);
      past       = cur_end > {1'b0, alloc_bits};
      span       = (NBITS_W+1)'(off) + (NBITS_W+1)'(step_bits) - (NBITS_W+1)'(1);
      last_k     = span[BYTE_IDX_W+2:3];
      mask32     = (step_bits >= NBITS_W'(MAX_BITS)) ? '1
                 : ((MAX_BITS'(1) << step_bits) - MAX_BITS'(1));
      win_val    = WIN_W'(step_val & mask32) << off;
      win_mask   = WIN_W'(mask32) << off;
      rd_shift   = rwin_ff >> off;
      rd_bits    = rd_shift[MAX_BITS-1:0] & mask32;
      cur_addr   = base + ADDR_W'(k_ff);
   end

   always_comb begin
      mem_req.we    = 1'b0;
      mem_req.waddr = cur_addr;
      mem_req.wdata = (mem_rdata & ~wmask_ff[7:0]) | wval_ff[7:0];
      mem_req.raddr = cur_addr + ADDR_W'(1);
      unique case (state_ff)
         S_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_addr_ff;
            mem_req.wdata = 8'h00;
         end
         S_STEP: begin
            mem_req.raddr = base;
         end
         S_RMW: begin
            mem_req.we = is_wr;
         end
         S_IDLE, S_FIN, S_RESP: begin
            mem_req.we = 1'b0;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      rsp_word.ok          = (status_ff == ST_NONE);
      rsp_word.read_value  = rval_ff;
      rsp_word.status      = status_ff;
      rsp_word.cursor_bits = cursor_ff;
      rsp_word.used_bytes  = cursor_ff[CURSOR_W-1:3] + ALLOC_W'(|cursor_ff[2:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_reply_ff <= 1'b0;
         tag_phase_ff <= 1'b0;
         cursor_ff    <= '0;
         alloc_ff     <= '0;
         k_ff         <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
               if (clr_addr_ff == ADDR_W'(STORE_BYTES - 1)) begin
                  state_ff <= clr_reply_ff ? S_RESP : S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  item_ff   <= req_word;
                  status_ff <= ST_NONE;
                  rval_ff   <= '0;
                  unique case (req_word.op)
                     OP_WRITE, OP_READ: begin
                        tag_phase_ff <= use_tags & req_word.typed;
                        state_ff     <= S_STEP;
                     end
                     OP_REWIND: begin
                        cursor_ff <= '0;
                        state_ff  <= S_RESP;
                     end
                     OP_CLEAR: begin
                        cursor_ff    <= '0;
                        alloc_ff     <= '0;
                        clr_addr_ff  <= '0;
                        clr_reply_ff <= 1'b1;
                        state_ff     <= S_CLEAR;
                     end
                  endcase
               end
            end
            S_STEP: begin
               k_ff     <= '0;
               rwin_ff  <= '0;
               wval_ff  <= win_val;
               wmask_ff <= win_mask;
               priority if (step_bits == '0) begin
                  status_ff <= ST_ZERO;
                  state_ff  <= S_RESP;
               end else if (is_wr && full) begin
                  status_ff <= ST_FULL;
                  state_ff  <= S_RESP;
               end else if (!is_wr && past) begin
                  status_ff <= ST_PAST;
                  state_ff  <= S_RESP;
               end else begin
                  if (is_wr) begin
                     alloc_ff <= alloc_sum[ALLOC_W-1:0];
                  end
                  state_ff <= S_RMW;
               end
            end
            S_RMW: begin
               // one byte per cycle: read data arrives, merged byte goes back
               k_ff                         <= k_ff + BYTE_IDX_W'(1);
               rwin_ff[{k_ff, 3'b000} +: 8] <= mem_rdata;
               wval_ff                      <= wval_ff >> 8;
               wmask_ff                     <= wmask_ff >> 8;
               if (k_ff == last_k) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               cursor_ff <= cur_end[CURSOR_W-1:0];
               if (tag_phase_ff) begin
                  tag_phase_ff <= 1'b0;
                  // mismatched tag stays consumed
                  if (!is_wr && (rd_bits[TAG_BITS-1:0] != item_ff.tag)) begin
                     status_ff <= ST_TAG;
                     state_ff  <= S_RESP;
                  end else begin
                     state_ff <= S_STEP;
                  end
               end else begin
                  if (!is_wr) begin
                     rval_ff <= rd_bits;
                  end
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (rsp_ready) begin
                  clr_reply_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
         endcase
      end
   end

   `TBP_ASSERT_NOW(a_cursor_in_alloc, state_ff == S_IDLE, cursor_ff <= alloc_bits)
   `TBP_ASSERT_NOW(a_alloc_bound, 1'b1, alloc_ff <= ALLOC_W'(STORE_BYTES))
   `TBP_ASSERT_NOW(a_byte_count, state_ff == S_RMW, k_ff <= last_k)
   `TBP_ASSERT_NEXT(a_fin_exit, state_ff == S_FIN, state_ff == S_RESP || state_ff == S_STEP)

endmodule

[test/tbp_checker.sv]
// checker for the tagged bit packer: shadow store, predicted responses and comparison
module tbp_checker
   import tbp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // tag, nbits, write_value
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // op, typed
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,   // read_value, cursor_bits, used_bytes
   input  logic [RSP_TUSER_W-1:0] rsp_tuser,   // ok, status
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]            csr_pwdata,
   input  logic [31:0]            csr_prdata,
   input  logic                   csr_pready,
   output int                     fail_count,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_W-1:0] USE_TAGS_ADDR = CSR_ADDR_W'(4 * CSR_USE_TAGS);

   logic [7:0]   shadow_store [STORE_BYTES];
   int unsigned  shadow_cursor;
   int unsigned  shadow_alloc;
   logic         shadow_use_tags;
   rsp_word_type outcome_q [$];

   task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                  input logic [31:0] want_v);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got_v, want_v);
      fail_count++;
   endtask

   function automatic void clear_shadow();
      foreach (shadow_store[j]) shadow_store[j] = 8'h00;
      shadow_cursor = 0;
      shadow_alloc  = 0;
   endfunction

   // lsb-first pack at the cursor, allocation grows by bits/8 + 1 bytes
   function automatic status_type pack_field(input int unsigned bits, input logic [31:0] val);
      int unsigned i;
      int unsigned pos;
      if (bits == 0) return ST_ZERO;
      if (shadow_alloc + bits / 8 + 1 > STORE_BYTES) return ST_FULL;
      shadow_alloc += bits / 8 + 1;
      for (i = 0; i < bits; i++) begin
         pos = shadow_cursor + i;
         if (pos / 8 < STORE_BYTES) shadow_store[pos / 8][pos % 8] = val[i];
      end
      shadow_cursor += bits;
      return ST_NONE;
   endfunction

   function automatic status_type unpack_field(input int unsigned bits,
                                               output logic [31:0] val);
      int unsigned i;
      int unsigned pos;
      val = '0;
      if (bits == 0) return ST_ZERO;
      if (shadow_cursor + bits > shadow_alloc * 8) return ST_PAST;
      for (i = 0; i < bits; i++) begin
         pos = shadow_cursor + i;
         val[i] = (pos / 8 < STORE_BYTES) ? shadow_store[pos / 8][pos % 8] : 1'b0;
      end
      shadow_cursor += bits;
      return ST_NONE;
   endfunction

   function automatic rsp_word_type packer_outcome(input op_type op, input logic typed,
                                                   input logic [TAG_BITS-1:0] tag,
                                                   input logic [NBITS_W-1:0] nbits,
                                                   input logic [31:0] wval);
      rsp_word_type r;
      status_type   st;
      logic [31:0]  rval;
      logic [31:0]  got_tag;
      int unsigned  n;
      logic         tag_step;
      n = (nbits > MAX_BITS) ? MAX_BITS : nbits;
      st = ST_NONE;
      rval = '0;
      tag_step = shadow_use_tags && typed;
      case (op)
         OP_WRITE: begin
            if (tag_step) st = pack_field(TAG_BITS, {27'b0, tag});
            if (st == ST_NONE) st = pack_field(n, wval);
         end
         OP_READ: begin
            // a wrong tag stays consumed, the value is left unread
            if (tag_step) begin
               st = unpack_field(TAG_BITS, got_tag);
               if (st == ST_NONE && got_tag != {27'b0, tag}) st = ST_TAG;
            end
            if (st == ST_NONE) st = unpack_field(n, rval);
            if (st != ST_NONE) rval = '0;
         end
         OP_REWIND: shadow_cursor = 0;
         default: clear_shadow();
      endcase
      r.ok          = (st == ST_NONE);
      r.read_value  = rval;
      r.status      = st;
      r.cursor_bits = CURSOR_W'(shadow_cursor);
      r.used_bytes  = ALLOC_W'((shadow_cursor + 7) / 8);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         clear_shadow();
         shadow_use_tags = 1'b0;
         outcome_q.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == USE_TAGS_ADDR) shadow_use_tags = csr_pwdata[0];
            end else if (csr_paddr == USE_TAGS_ADDR &&
                         csr_prdata !== {31'b0, shadow_use_tags}) begin
               report_mismatch("use_tags readback", csr_prdata, {31'b0, shadow_use_tags});
            end
         end
         // results leave in a later cycle than their word, so pop before push
         if (rsp_tvalid && rsp_tready) begin
            got.ok          = rsp_tuser[0];
            got.status      = status_type'(rsp_tuser[3:1]);
            got.read_value  = rsp_tdata[31:0];
            got.cursor_bits = rsp_tdata[47:32];
            got.used_bytes  = rsp_tdata[60:48];
            if (outcome_q.size() == 0) begin
               report_mismatch("result word with none expected", rsp_tdata[31:0], '0);
            end else begin
               want = outcome_q.pop_front();
               if (got.ok !== want.ok)
                  report_mismatch("ok", {31'b0, got.ok}, {31'b0, want.ok});
               if (got.read_value !== want.read_value)
                  report_mismatch("read_value", got.read_value, want.read_value);
               if (got.status !== want.status)
                  report_mismatch("status", {29'b0, got.status}, {29'b0, want.status});
               if (got.cursor_bits !== want.cursor_bits)
                  report_mismatch("cursor_bits", {16'b0, got.cursor_bits},
                                  {16'b0, want.cursor_bits});
               if (got.used_bytes !== want.used_bytes)
                  report_mismatch("used_bytes", {19'b0, got.used_bytes},
                                  {19'b0, want.used_bytes});
            end
         end
         if (req_tvalid && req_tready)
            outcome_q.push_back(packer_outcome(op_type'(req_tuser[1:0]), req_tuser[2],
                                               req_tdata[4:0], req_tdata[10:5],
                                               req_tdata[42:11]));
      end
      pending = outcome_q.size();
   end

endmodule

[test/tb_top.sv]
// top of the tagged bit packer test: clock, reset, stimulus and verdict
module tb_top;
   import tbp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int FILL_WORDS  = 800;
   localparam int ITEM_TARGET = 1700;
   localparam logic [CSR_ADDR_W-1:0] USE_TAGS_ADDR = CSR_ADDR_W'(4 * CSR_USE_TAGS);

   typedef struct {
      logic                typed;
      logic [TAG_BITS-1:0] tag;
      logic [NBITS_W-1:0]  nbits;
   } field_rec_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [31:0]            csr_pwdata;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   int            fail_count;
   int            pending;
   int            sent;
   int            cycle_count;
   logic          no_idle;
   field_rec_type written_q [$];

   tagged_bit_packer_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   tbp_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tagged_bit_packer_top test failed");
      $finish;
   end

   // result side: a fresh random stall, possibly none, before every word
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_word(input op_type op, input logic typed,
                            input logic [TAG_BITS-1:0] tag,
                            input logic [NBITS_W-1:0] nbits, input logic [31:0] val);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, val, nbits, tag};
      req_tuser  <= {typed, op};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // stop sending and wait until every outstanding word has its result
   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic apb_access(input logic wr, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= USE_TAGS_ADDR;
      csr_pwdata  <= data;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_use_tags(input logic v);
      drain();
      apb_access(1'b1, {31'b0, v});
      apb_access(1'b0, '0);
   endtask

   initial begin
      field_rec_type        rec;
      op_type               op;
      logic                 typed;
      logic [TAG_BITS-1:0]  tag;
      logic [NBITS_W-1:0]   nbits;
      int                   k;
      int                   pick;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      no_idle     = 1'b0;
      sent        = 0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // untyped packing, width extremes and saturation
      set_use_tags(1'b0);
      send_word(OP_READ,   1'b0, 5'd0,  6'd5,  '0);           // nothing allocated yet
      send_word(OP_WRITE,  1'b0, 5'd0,  6'd0,  32'h1234_5678); // zero width
      send_word(OP_WRITE,  1'b0, 5'd0,  6'd32, 32'hFFFF_FFFF);
      send_word(OP_WRITE,  1'b0, 5'd0,  6'd1,  32'h0000_0000);
      send_word(OP_WRITE,  1'b0, 5'd31, 6'd63, 32'hA5A5_5A5A); // saturates to 32
      send_word(OP_WRITE,  1'b1, 5'd7,  6'd8,  32'h0000_00C3); // typed but tags off
      send_word(OP_REWIND, 1'b0, 5'd0,  6'd0,  '0);
      send_word(OP_READ,   1'b0, 5'd0,  6'd32, '0);
      send_word(OP_READ,   1'b0, 5'd0,  6'd1,  '0);
      send_word(OP_READ,   1'b0, 5'd0,  6'd40, '0);
      send_word(OP_READ,   1'b0, 5'd0,  6'd0,  '0);
      send_word(OP_READ,   1'b1, 5'd7,  6'd8,  '0);
      send_word(OP_READ,   1'b0, 5'd0,  6'd32, '0);           // runs past the end

      // typed packing with bool, int32 and uint32 tags
      set_use_tags(1'b1);
      send_word(OP_CLEAR,  1'b0, 5'd0,  6'd0,  '0);
      send_word(OP_READ,   1'b1, 5'd1,  6'd1,  '0);           // tag past end
      send_word(OP_WRITE,  1'b1, 5'd1,  6'd1,  32'h0000_0001);
      send_word(OP_WRITE,  1'b1, 5'd7,  6'd32, 32'h8000_0000);
      send_word(OP_WRITE,  1'b1, 5'd8,  6'd0,  '0);           // tag lands, value zero width
      send_word(OP_WRITE,  1'b1, 5'd31, 6'd6,  32'h0000_003F);
      send_word(OP_REWIND, 1'b0, 5'd0,  6'd0,  '0);
      send_word(OP_READ,   1'b1, 5'd1,  6'd1,  '0);
      send_word(OP_READ,   1'b1, 5'd8,  6'd32, '0);           // wrong tag
      send_word(OP_REWIND, 1'b0, 5'd0,  6'd0,  '0);
      send_word(OP_READ,   1'b1, 5'd0,  6'd32, '0);
      send_word(OP_READ,   1'b0, 5'd0,  6'd63, '0);

      // run the store into overflow with mostly wide writes, typed at random
      send_word(OP_CLEAR, 1'b0, 5'd0, 6'd0, '0);
      repeat (FILL_WORDS) begin
         nbits = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(24, 63));
         send_word(OP_WRITE, 1'($urandom), 5'($urandom), nbits, $urandom);
      end
      send_word(OP_REWIND, 1'b0, 5'd0, 6'd0, '0);
      repeat (60)
         send_word(OP_READ, 1'($urandom), 5'($urandom), 6'($urandom_range(0, 63)), $urandom);

      // rounds of write, rewind, read back, with noise between them
      for (int ph = 0; ph < 4; ph++) begin
         set_use_tags(1'(ph % 2));
         while (sent < ITEM_TARGET * (ph + 1) / 4 + (FILL_WORDS * (3 - ph)) / 4) begin
            no_idle = ($urandom_range(0, 3) == 0);
            written_q.delete();
            if ($urandom_range(0, 39) == 0) send_word(OP_CLEAR, 1'b0, 5'd0, 6'd0, '0);
            else send_word(OP_REWIND, 1'($urandom), 5'($urandom), 6'($urandom), $urandom);
            k = $urandom_range(1, 10);
            repeat (k) begin
               pick = $urandom_range(0, 15);
               rec.typed = 1'($urandom);
               rec.tag   = 5'($urandom);
               rec.nbits = (pick == 0) ? 6'd0 :
                           (pick == 1) ? 6'($urandom_range(33, 63)) :
                                         6'($urandom_range(1, 32));
               written_q.push_back(rec);
               send_word(OP_WRITE, rec.typed, rec.tag, rec.nbits, $urandom);
            end
            send_word(OP_REWIND, 1'b0, 5'd0, 6'd0, '0);
            foreach (written_q[j]) begin
               rec = written_q[j];
               pick = $urandom_range(0, 7);
               if (pick == 0) rec.tag = rec.tag ^ 5'($urandom_range(1, 31));
               if (pick == 1) rec.nbits = 6'($urandom_range(0, 63));
               if (pick == 2) rec.typed = ~rec.typed;
               send_word(OP_READ, rec.typed, rec.tag, rec.nbits, $urandom);
            end
            if ($urandom_range(0, 2) == 0)
               send_word(OP_READ, 1'($urandom), 5'($urandom), 6'($urandom_range(1, 63)), '0);
            repeat ($urandom_range(0, 2)) begin
               op = op_type'(2'($urandom_range(0, 2)));
               if ($urandom_range(0, 31) == 0) op = OP_CLEAR;
               typed = 1'($urandom);
               tag   = 5'($urandom);
               send_word(op, typed, tag, 6'($urandom), $urandom);
            end
            if ($urandom_range(0, 15) == 0) drain();
         end
      end

      no_idle = 1'b0;
      drain();
      repeat (30) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tagged_bit_packer_top test passed");
      end else begin
         $display("tagged_bit_packer_top test failed");
      end
      $finish;
   end

endmodule

[tagged_bit_packer_top.f]
+incdir+rtl
rtl/tbp_pkg.sv
rtl/tbp_store.sv
rtl/tbp_engine.sv
rtl/tagged_bit_packer_top.sv
test/tbp_checker.sv
test/tb_top.sv
